[rtl/core/dbmc_pkg.sv]
// ----------------------------------------------------------------------------
// dbmc_pkg
// Shared types and constants of the debounced button menu controller.
// ----------------------------------------------------------------------------
package dbmc_pkg;

   localparam int NUM_BUTTONS = 4;
   localparam int MENU_ROWS   = 7;
   localparam int ROW_BITS    = 3;
   localparam int ACT_BITS    = 4;
   localparam int RDR_BITS    = 2;
   localparam int CFG_BITS    = 16;
   localparam int NOW_BITS    = 32;
   localparam int CODE_BITS   = 8;
   localparam int REG_IDX_BITS = 2;

   localparam logic [ROW_BITS-1:0] ALT_ROW = 3'd6;

   localparam int BTN_UP   = 0;
   localparam int BTN_DOWN = 1;
   localparam int BTN_OK   = 2;
   localparam int BTN_BACK = 3;

   localparam logic [ACT_BITS-1:0] ACT_NONE = 4'd0;
   localparam logic [ACT_BITS-1:0] ACT_STOP = 4'd8;

   localparam logic [RDR_BITS-1:0] RDR_NONE   = 2'd0;
   localparam logic [RDR_BITS-1:0] RDR_STATUS = 2'd1;
   localparam logic [RDR_BITS-1:0] RDR_MENU   = 2'd2;
   localparam logic [RDR_BITS-1:0] RDR_NOTICE = 2'd3;

   localparam logic [REG_IDX_BITS-1:0] REG_DEBOUNCE  = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_LONG_HOLD = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_REFRESH   = 2'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_NOTICE    = 2'd3;

   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET  = 16'd30;
   localparam logic [CFG_BITS-1:0] LONG_HOLD_RESET = 16'd900;
   localparam logic [CFG_BITS-1:0] REFRESH_RESET   = 16'd250;
   localparam logic [CFG_BITS-1:0] NOTICE_RESET    = 16'd1800;

   typedef struct packed {
      logic [NOW_BITS-1:0]    now_ms;
      logic [NUM_BUTTONS-1:0] buttons_raw;
      logic                   critical;
      logic                   alt_row_present;
      logic [CODE_BITS-1:0]   gain_code;
      logic [CODE_BITS-1:0]   alt_gain_code;
      logic                   notice_start;
   } req_item_type;

   typedef struct packed {
      logic [ACT_BITS-1:0] action;
      logic [RDR_BITS-1:0] redraw;
      logic                screen_now;
      logic [ROW_BITS-1:0] cursor_row;
   } rsp_item_type;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] press;
      logic [NUM_BUTTONS-1:0] hold;
   } btn_evt_type;

endpackage

[rtl/core/dbmc_if.sv]
// ----------------------------------------------------------------------------
// dbmc channel interfaces
// Valid/ready channels for item requests, results and register writes.
// ----------------------------------------------------------------------------
interface dbmc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [3:0]  buttons_raw;
   logic        critical;
   logic        alt_row_present;
   logic [7:0]  gain_code;
   logic [7:0]  alt_gain_code;
   logic        notice_start;

   modport source (output valid, now_ms, buttons_raw, critical, alt_row_present,
                   gain_code, alt_gain_code, notice_start, input ready);
   modport sink   (input valid, now_ms, buttons_raw, critical, alt_row_present,
                   gain_code, alt_gain_code, notice_start, output ready);
endinterface

interface dbmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] action;
   logic [1:0] redraw;
   logic       screen_now;
   logic [2:0] cursor_row;

   modport source (output valid, action, redraw, screen_now, cursor_row, input ready);
   modport sink   (input valid, action, redraw, screen_now, cursor_row, output ready);
endinterface

interface dbmc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/debounced_button_menu_controller.sv]
// ----------------------------------------------------------------------------
// debounced_button_menu_controller
// Debounces four buttons against millisecond timestamps and runs the menu.
// ----------------------------------------------------------------------------
// usage:
//   req_bus carries one tick item (timestamp, raw buttons, window flags,
//   gain codes, notice request); each accepted beat gives exactly one beat
//   on rsp_bus (action, redraw request, screen and cursor after the item).
//   csr_bus writes the four timing registers; write them only while the block
//   is idle, which the block itself does not enforce; csr_bus is always ready.
//   a request beat is registered in the input register, then worked on once the
//   result register is free and written to it; that register drives rsp_bus.
//   throughput: one item per cycle unless rsp_bus stalls; menu state and (but
//   for notice items) button state are updated from the input register.
//   reset clears all button and menu state, raises a pending redraw and
//   restores the register defaults (30, 900, 250, 1800 ms).
//   when rsp_bus stalls, one further item is held in the input register and
//   req_bus.ready drops until the result register frees.
// ----------------------------------------------------------------------------
module debounced_button_menu_controller #(
   parameter int TIME_BITS = 32
) (
   input logic          clock,
   input logic          reset,
   dbmc_req_if.sink     req_bus,
   dbmc_rsp_if.source   rsp_bus,
   dbmc_csr_if.sink     csr_bus
);

   logic [dbmc_pkg::CFG_BITS-1:0] debounce_ff, long_hold_ff, refresh_ff, notice_ff;
   logic                          in_valid_ff, in_valid_in;
   dbmc_pkg::req_item_type        in_item_ff;
   logic                          out_valid_ff, out_valid_in;
   dbmc_pkg::rsp_item_type        out_item_ff, result;
   dbmc_pkg::btn_evt_type         evt;
   logic                          out_free, process, take_req, btn_step;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign process  = in_valid_ff && out_free;
   assign req_bus.ready = !in_valid_ff || out_free;
   assign take_req = req_bus.valid && req_bus.ready;
   assign btn_step = process && !in_item_ff.notice_start;
   assign csr_bus.ready = 1'b1;

   assign in_valid_in  = take_req || (in_valid_ff && !process);
   assign out_valid_in = process || (out_valid_ff && !rsp_bus.ready);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= dbmc_pkg::DEBOUNCE_RESET;
         long_hold_ff <= dbmc_pkg::LONG_HOLD_RESET;
         refresh_ff   <= dbmc_pkg::REFRESH_RESET;
         notice_ff    <= dbmc_pkg::NOTICE_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            dbmc_pkg::REG_DEBOUNCE:  debounce_ff  <= csr_bus.data;
            dbmc_pkg::REG_LONG_HOLD: long_hold_ff <= csr_bus.data;
            dbmc_pkg::REG_REFRESH:   refresh_ff   <= csr_bus.data;
            dbmc_pkg::REG_NOTICE:    notice_ff    <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_item_ff.now_ms          <= req_bus.now_ms;
         in_item_ff.buttons_raw     <= req_bus.buttons_raw;
         in_item_ff.critical        <= req_bus.critical;
         in_item_ff.alt_row_present <= req_bus.alt_row_present;
         in_item_ff.gain_code       <= req_bus.gain_code;
         in_item_ff.alt_gain_code   <= req_bus.alt_gain_code;
         in_item_ff.notice_start    <= req_bus.notice_start;
      end
      if (process) begin
         out_item_ff <= result;
      end
   end

   for (genvar b = 0; b < dbmc_pkg::NUM_BUTTONS; b++) begin : g_btn
      dbmc_button #(
         .TIME_BITS (TIME_BITS)
      ) u_button (
         .clock          (clock),
         .reset          (reset),
         .step           (btn_step),
         .now            (in_item_ff.now_ms[TIME_BITS-1:0]),
         .level          (in_item_ff.buttons_raw[b]),
         .debounce_time  (debounce_ff),
         .long_hold_time (long_hold_ff),
         .press          (evt.press[b]),
         .hold           (evt.hold[b])
      );
   end

   dbmc_menu #(
      .TIME_BITS (TIME_BITS)
   ) u_menu (
      .clock          (clock),
      .reset          (reset),
      .step           (process),
      .item           (in_item_ff),
      .evt            (evt),
      .refresh_period (refresh_ff),
      .notice_time    (notice_ff),
      .result         (result)
   );

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.action     = out_item_ff.action;
   assign rsp_bus.redraw     = out_item_ff.redraw;
   assign rsp_bus.screen_now = out_item_ff.screen_now;
   assign rsp_bus.cursor_row = out_item_ff.cursor_row;

endmodule

[rtl/core/dbmc_button.sv]
// ----------------------------------------------------------------------------
// dbmc_button
// Debouncer for one button with press and one-shot long-hold events.
// ----------------------------------------------------------------------------
module dbmc_button #(
   parameter int TIME_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [TIME_BITS-1:0]         now,
   input  logic                         level,
   input  logic [dbmc_pkg::CFG_BITS-1:0] debounce_time,
   input  logic [dbmc_pkg::CFG_BITS-1:0] long_hold_time,
   output logic                         press,
   output logic                         hold
);

   logic                 raw_ff, raw_in;
   logic                 stable_ff, stable_in;
   logic                 long_done_ff, long_done_in;
   logic [TIME_BITS-1:0] change_ff, change_in;
   logic [TIME_BITS-1:0] press_ff, press_in;
   logic [TIME_BITS-1:0] deb_diff, hold_diff;
   logic                 settle, done_eff;

   always_comb begin
      raw_in    = level;
      change_in = (level != raw_ff) ? now : change_ff;
      deb_diff  = now - change_in;
      settle    = (stable_ff != level) && (32'(deb_diff) >= 32'(debounce_time));
      press     = settle && level;
      stable_in = settle ? level : stable_ff;
      press_in  = press ? now : press_ff;
      done_eff  = press ? 1'b0 : long_done_ff;
      hold_diff = now - press_in;
      hold      = stable_in && !done_eff && (32'(hold_diff) >= 32'(long_hold_time));
      long_done_in = done_eff || hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff       <= 1'b0;
         stable_ff    <= 1'b0;
         long_done_ff <= 1'b0;
         change_ff    <= '0;
         press_ff     <= '0;
      end else if (step) begin
         raw_ff       <= raw_in;
         stable_ff    <= stable_in;
         long_done_ff <= long_done_in;
         change_ff    <= change_in;
         press_ff     <= press_in;
      end
   end

endmodule

[rtl/core/dbmc_menu.sv]
// ----------------------------------------------------------------------------
// dbmc_menu
// Screen, cursor, notice, critical window and redraw handling.
// ----------------------------------------------------------------------------
module dbmc_menu #(
   parameter int TIME_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  dbmc_pkg::req_item_type        item,
   input  dbmc_pkg::btn_evt_type         evt,
   input  logic [dbmc_pkg::CFG_BITS-1:0] refresh_period,
   input  logic [dbmc_pkg::CFG_BITS-1:0] notice_time,
   output dbmc_pkg::rsp_item_type        result
);

   localparam int RB = dbmc_pkg::ROW_BITS;

   logic                  screen_ff, screen_in;
   logic [RB-1:0]         cursor_ff, cursor_in;
   logic                  crit_ff, crit_in;
   logic                  redraw_req_ff, redraw_req_in;
   logic [TIME_BITS-1:0]  last_ff, last_in;
   logic [TIME_BITS-1:0]  deadline_ff, deadline_in;
   logic                  notice_ff, notice_in;
   logic [dbmc_pkg::CODE_BITS-1:0] seen_gain_ff, seen_gain_in;
   logic [dbmc_pkg::CODE_BITS-1:0] seen_alt_gain_ff, seen_alt_gain_in;
   logic                  seen_alt_ff, seen_alt_in;
   logic [TIME_BITS-1:0]  now;
   logic [TIME_BITS-1:0]  notice_diff, refresh_diff;

   function automatic logic [RB-1:0] row_step(input logic [RB-1:0] row, input logic up,
                                              input logic alt);
      logic [RB-1:0] r;
      begin
         r = row;
         for (int k = 0; k < 2; k++) begin
            if (k == 0 || (r == dbmc_pkg::ALT_ROW && !alt)) begin
               if (up) begin
                  r = (r == '0) ? RB'(dbmc_pkg::MENU_ROWS - 1) : r - 1'b1;
               end else begin
                  r = (r == RB'(dbmc_pkg::MENU_ROWS - 1)) ? '0 : r + 1'b1;
               end
            end
         end
         return r;
      end
   endfunction

   assign now          = item.now_ms[TIME_BITS-1:0];
   assign notice_diff  = now - deadline_ff;
   assign refresh_diff = now - last_ff;

   always_comb begin
      screen_in        = screen_ff;
      cursor_in        = cursor_ff;
      crit_in          = crit_ff;
      redraw_req_in    = redraw_req_ff;
      last_in          = last_ff;
      deadline_in      = deadline_ff;
      notice_in        = notice_ff;
      seen_gain_in     = seen_gain_ff;
      seen_alt_gain_in = seen_alt_gain_ff;
      seen_alt_in      = seen_alt_ff;
      result.action    = dbmc_pkg::ACT_NONE;
      result.redraw    = dbmc_pkg::RDR_NONE;

      if (item.notice_start) begin
         deadline_in   = now + TIME_BITS'(notice_time);
         notice_in     = 1'b1;
         result.redraw = dbmc_pkg::RDR_NOTICE;
      end else begin
         if (item.gain_code != seen_gain_ff || item.alt_gain_code != seen_alt_gain_ff ||
             item.alt_row_present != seen_alt_ff) begin
            seen_gain_in     = item.gain_code;
            seen_alt_gain_in = item.alt_gain_code;
            seen_alt_in      = item.alt_row_present;
            redraw_req_in    = 1'b1;
         end
         if (item.critical) begin
            crit_in = 1'b1;
            if (evt.hold[dbmc_pkg::BTN_BACK]) begin
               result.action = dbmc_pkg::ACT_STOP;
            end
         end else begin
            if (crit_ff) begin
               crit_in       = 1'b0;
               redraw_req_in = 1'b1;
            end
            if (!(notice_ff && notice_diff[TIME_BITS-1])) begin
               if (notice_ff) begin
                  notice_in     = 1'b0;
                  deadline_in   = '0;
                  redraw_req_in = 1'b1;
               end
               if (!screen_ff) begin
                  if (evt.press[dbmc_pkg::BTN_OK]) begin
                     screen_in     = 1'b1;
                     redraw_req_in = 1'b1;
                  end
               end else begin
                  if (evt.press[dbmc_pkg::BTN_UP]) begin
                     cursor_in     = row_step(cursor_in, 1'b1, item.alt_row_present);
                     redraw_req_in = 1'b1;
                  end
                  if (evt.press[dbmc_pkg::BTN_DOWN]) begin
                     cursor_in     = row_step(cursor_in, 1'b0, item.alt_row_present);
                     redraw_req_in = 1'b1;
                  end
                  if (evt.press[dbmc_pkg::BTN_BACK]) begin
                     screen_in     = 1'b0;
                     redraw_req_in = 1'b1;
                  end
               end
               if (screen_ff && evt.press[dbmc_pkg::BTN_OK]) begin
                  // redraw stays pending
                  result.action = dbmc_pkg::ACT_BITS'(cursor_in) + 1'b1;
               end else if (redraw_req_in ||
                            32'(refresh_diff) >= 32'(refresh_period)) begin
                  last_in       = now;
                  redraw_req_in = 1'b0;
                  result.redraw = screen_in ? dbmc_pkg::RDR_MENU : dbmc_pkg::RDR_STATUS;
               end
            end
         end
      end
      result.screen_now = screen_in;
      result.cursor_row = cursor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff        <= 1'b0;
         cursor_ff        <= '0;
         crit_ff          <= 1'b0;
         redraw_req_ff    <= 1'b1;
         last_ff          <= '0;
         deadline_ff      <= '0;
         notice_ff        <= 1'b0;
         seen_gain_ff     <= '0;
         seen_alt_gain_ff <= '0;
         seen_alt_ff      <= 1'b0;
      end else if (step) begin
         screen_ff        <= screen_in;
         cursor_ff        <= cursor_in;
         crit_ff          <= crit_in;
         redraw_req_ff    <= redraw_req_in;
         last_ff          <= last_in;
         deadline_ff      <= deadline_in;
         notice_ff        <= notice_in;
         seen_gain_ff     <= seen_gain_in;
         seen_alt_gain_ff <= seen_alt_gain_in;
         seen_alt_ff      <= seen_alt_in;
      end
   end

endmodule
